### design/bav_pkg.sv
// Package for the 3x3 block average downsampler.
// Holds field widths, register indexes, the queue item type and the reciprocal table.
// No dependencies.
package bav_pkg;

	localparam int BLOCK_SIZE = 3;
	localparam int MAX_COUNT = BLOCK_SIZE * BLOCK_SIZE;
	localparam int PIX_W = 8;
	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int IDX_OUT_W = 9;
	localparam int DIM_W = 11;
	localparam int DIM_RESET = 1024;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_OUT_W = 48;
	localparam int NUM_W = SUM_W + 1;
	localparam int RECIP_W = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// One classified pixel on its way from the front end to the back end.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic first;
		logic emit;
		logic done;
		logic [CNT_W-1:0] count;
		logic [IDX_OUT_W-1:0] block_row;
		logic [IDX_OUT_W-1:0] block_col;
	} bav_item_t;

	// ceil(2^18 / (2 * count)); exact floor division for numerators below 2^13.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] r;
		case (count)
			4'd1: r = 18'd131072;
			4'd2: r = 18'd65536;
			4'd3: r = 18'd43691;
			4'd4: r = 18'd32768;
			4'd5: r = 18'd26215;
			4'd6: r = 18'd21846;
			4'd7: r = 18'd18725;
			4'd8: r = 18'd16384;
			4'd9: r = 18'd14564;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### design/bav_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bav_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 342,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read and a write to the same address in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/bav_fifo.sv
// Short flop-based queue between the front end and the back end.
// No dependencies.
module bav_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign in_ready = (fill_q != FILL_W'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_data = mem_q[rd_ptr_q];
	assign do_push = in_valid && in_ready;
	assign do_pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("queue fill count beyond depth");

	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> fill_q == $past(fill_q) + 1'b1)
		else $error("queue fill count did not follow a lone push");
`endif

endmodule

### design/bav_front.sv
// Front end: configuration registers, raster position counters and block classification.
// Depends on bav_pkg.
module bav_front import bav_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int BAND_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
	localparam int BC_W = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIX_W-1:0]     s_tdata,
	output logic                 item_valid,
	input  logic                 item_ready,
	output bav_item_t            item,
	output logic [BC_W-1:0]      item_addr
);

	localparam int POS_W = $clog2(MAX_WIDTH);
	localparam int DIM_CAP = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
	localparam logic [POS_W-1:0] LAST_RESET = POS_W'(DIM_CAP - 1);
	localparam logic [1:0] SUB_LAST = 2'(BLOCK_SIZE - 1);

	logic [POS_W-1:0]     wlast_q;
	logic [POS_W-1:0]     hlast_q;
	logic [POS_W-1:0]     pcol_q;
	logic [POS_W-1:0]     prow_q;
	logic [1:0]           rib_q;
	logic [1:0]           cib_q;
	logic [BC_W-1:0]      bcol_q;
	logic [BC_W-1:0]      brow_q;
	logic [POS_W-1:0]     cfg_last;
	logic                 wr_w;
	logic                 wr_h;
	logic                 accept;
	logic                 last_col;
	logic                 last_row;
	logic                 blk_right;
	logic                 blk_bottom;
	logic [CNT_W-1:0]     cols_n;
	logic [CNT_W-1:0]     rows_n;
	logic [2*CNT_W-1:0]   cnt_full;

	// Dimensions are kept as last index; zero is taken as one and large values saturate.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_last = '0;
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			cfg_last = POS_W'(MAX_WIDTH - 1);
		end else begin
			cfg_last = POS_W'(cfg_data - DIM_W'(1));
		end
	end

	always_comb begin
		wr_w = 1'b0;
		wr_h = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: wr_w = 1'b1;
				REG_IMAGE_HEIGHT: wr_h = 1'b1;
				default: ;
			endcase
		end
	end

	assign s_tready = item_ready;
	assign item_valid = s_tvalid;
	assign accept = s_tvalid && item_ready;

	assign last_col = (pcol_q == wlast_q);
	assign last_row = (prow_q == hlast_q);
	assign blk_right = (cib_q == SUB_LAST) || last_col;
	assign blk_bottom = (rib_q == SUB_LAST) || last_row;
	assign cols_n = CNT_W'(cib_q) + 1'b1;
	assign rows_n = CNT_W'(rib_q) + 1'b1;
	assign cnt_full = cols_n * rows_n;

	assign item.pixel = s_tdata;
	assign item.first = (rib_q == '0) && (cib_q == '0);
	assign item.emit = blk_right && blk_bottom;
	assign item.done = last_col && last_row;
	assign item.count = cnt_full[CNT_W-1:0];
	assign item.block_row = IDX_OUT_W'(brow_q);
	assign item.block_col = IDX_OUT_W'(bcol_q);
	assign item_addr = bcol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= LAST_RESET;
			hlast_q <= LAST_RESET;
			pcol_q <= '0;
			prow_q <= '0;
			rib_q <= '0;
			cib_q <= '0;
			bcol_q <= '0;
			brow_q <= '0;
		end else if (wr_w || wr_h) begin
			// Any register write starts a new image.
			if (wr_w) begin
				wlast_q <= cfg_last;
			end
			if (wr_h) begin
				hlast_q <= cfg_last;
			end
			pcol_q <= '0;
			prow_q <= '0;
			rib_q <= '0;
			cib_q <= '0;
			bcol_q <= '0;
			brow_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				pcol_q <= '0;
				cib_q <= '0;
				bcol_q <= '0;
				if (last_row) begin
					prow_q <= '0;
					rib_q <= '0;
					brow_q <= '0;
				end else begin
					prow_q <= prow_q + 1'b1;
					if (rib_q == SUB_LAST) begin
						rib_q <= '0;
						brow_q <= brow_q + 1'b1;
					end else begin
						rib_q <= rib_q + 1'b1;
					end
				end
			end else begin
				pcol_q <= pcol_q + 1'b1;
				if (cib_q == SUB_LAST) begin
					cib_q <= '0;
					bcol_q <= bcol_q + 1'b1;
				end else begin
					cib_q <= cib_q + 1'b1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		pcol_q <= wlast_q && prow_q <= hlast_q)
		else $error("pixel position outside the configured image");
`endif

endmodule

### design/bav_back.sv
// Back end: band sum store with read-modify-write, divider by reciprocal and output register.
// Depends on bav_pkg and bav_ram.
module bav_back import bav_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int BAND_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
	localparam int BC_W = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bav_item_t              in_item,
	input  logic [BC_W-1:0]        in_addr,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,
	output logic                   m_tlast
);

	localparam int PROD_W = NUM_W + RECIP_W;
	localparam int PAD_W = TDATA_OUT_W - PIX_W - SUM_W - CNT_W - 2 * IDX_OUT_W;

	logic                 adv;
	logic                 pop;
	logic                 we;
	logic                 v_s2;
	logic                 v_s3;
	logic                 m_valid_q;
	logic                 fwd_v_q;
	bav_item_t            item_s2;
	bav_item_t            item_s3;
	logic [BC_W-1:0]      addr_s2;
	logic [BC_W-1:0]      fwd_addr_q;
	logic [SUM_W-1:0]     fwd_sum_q;
	logic [SUM_W-1:0]     ram_rdata;
	logic [SUM_W-1:0]     prev_sum;
	logic [SUM_W-1:0]     acc_sum;
	logic [SUM_W-1:0]     sum_s3;
	logic [NUM_W-1:0]     numer;
	logic [RECIP_W-1:0]   recip;
	logic [PROD_W-1:0]    prod;
	logic [PIX_W-1:0]     avg_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_OUT_W-1:0] brow_q;
	logic [IDX_OUT_W-1:0] bcol_q;
	logic                 done_q;

	// The whole back end moves as one pipeline whenever the output register can take a result.
	assign adv = !m_valid_q || m_tready;
	assign pop = in_valid && adv;
	assign in_ready = adv;
	assign we = v_s2 && adv;

	bav_ram #(
		.WIDTH(SUM_W),
		.DEPTH(BAND_DEPTH)
	) u_band_ram (
		.clk(clk),
		.we(we),
		.waddr(addr_s2),
		.wdata(acc_sum),
		.re(pop),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	// The last write is kept so that a read that raced it still sees the newest sum.
	assign prev_sum = (fwd_v_q && fwd_addr_q == addr_s2) ? fwd_sum_q : ram_rdata;
	assign acc_sum = item_s2.first ? SUM_W'(item_s2.pixel)
		: prev_sum + SUM_W'(item_s2.pixel);

	// Rounded average is floor((2*sum + count) / (2*count)), done as a reciprocal multiply.
	assign numer = {sum_s3, 1'b0} + NUM_W'(item_s3.count);
	assign recip = recip_of(item_s3.count);
	assign prod = PROD_W'(numer) * PROD_W'(recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			m_valid_q <= 1'b0;
			fwd_v_q <= 1'b0;
		end else if (adv) begin
			v_s2 <= pop;
			v_s3 <= v_s2 && item_s2.emit;
			m_valid_q <= v_s3;
			if (we) begin
				fwd_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= in_item;
			addr_s2 <= in_addr;
			item_s3 <= item_s2;
			sum_s3 <= acc_sum;
			avg_q <= prod[RECIP_SHIFT +: PIX_W];
			sum_q <= sum_s3;
			cnt_q <= item_s3.count;
			brow_q <= item_s3.block_row;
			bcol_q <= item_s3.block_col;
			done_q <= item_s3.done;
		end
		if (we) begin
			fwd_addr_q <= addr_s2;
			fwd_sum_q <= acc_sum;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {{PAD_W{1'b0}}, bcol_q, brow_q, cnt_q, sum_q, avg_q};
	assign m_tlast = done_q;

`ifndef NO_ASSERTIONS
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv |=> v_s2 && $stable(addr_s2))
		else $error("accumulate stage lost its item during a stall");

	a_emit_reaches_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && adv && item_s2.emit |=> v_s3)
		else $error("finished block did not enter the divide stage");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> item_s3.count != '0 && item_s3.count <= CNT_W'(MAX_COUNT))
		else $error("block pixel count out of range");
`endif

endmodule

### design/block_average_3x3.sv
// Top level of the 3x3 block average downsampler.
// Depends on bav_pkg, bav_front, bav_fifo, bav_back (and bav_ram through bav_back).
//
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tdata: pixel
// m_*       out        m_tvalid / m_tready   m_tdata: block result, m_tlast: image_done
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per clock is taken in steady state; the band sum store has one write and
// one registered read port, and a same-address bypass lets a block's pixels follow
// back to back. Reset is asynchronous; both dimensions come up as 1024, saturated at
// MAX_WIDTH. The store needs no clearing pass. A stalled output holds the back end
// and, once the queue fills, the input; cfg_ready is always high.
module block_average_3x3 import bav_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,    // [7:0] pixel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [7:0] average, [19:8] block_sum, [23:20] pixel_count,
	// [32:24] block_row, [41:33] block_col, [47:42] zero
	output logic [TDATA_OUT_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DIM_W-1:0]       cfg_data
);

	localparam int BAND_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int BC_W = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
	localparam int Q_W = BC_W + $bits(bav_item_t);

	logic            fe_valid;
	logic            fe_ready;
	bav_item_t       fe_item;
	logic [BC_W-1:0] fe_addr;
	logic            q_valid;
	logic            q_ready;
	logic [Q_W-1:0]  q_data;
	bav_item_t       be_item;
	logic [BC_W-1:0] be_addr;

	assign cfg_ready = 1'b1;

	bav_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.item_valid(fe_valid),
		.item_ready(fe_ready),
		.item(fe_item),
		.item_addr(fe_addr)
	);

	bav_fifo #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fe_valid),
		.in_ready(fe_ready),
		.in_data({fe_addr, fe_item}),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data(q_data)
	);

	assign be_item = q_data[$bits(bav_item_t)-1:0];
	assign be_addr = q_data[Q_W-1 -: BC_W];

	bav_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.in_ready(q_ready),
		.in_item(be_item),
		.in_addr(be_addr),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

### test/tb_block_average_3x3.sv
// Self-checking testbench for block_average_3x3, the 3x3 block mean downsampler.
// Predicts every block result from the accepted pixels; depends on bav_pkg and the RTL.
`timescale 1ns / 100ps

module tb_block_average_3x3 import bav_pkg::*; ();

	localparam int MAX_WIDTH = 1024;
	localparam int BAND_DEPTH = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 200;
	localparam int STUCK_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 560;
	localparam int IDLE_PCT = 22;
	localparam int MAX_REPORTS = 10;
	localparam int FILL_MIXED = 0;
	localparam int FILL_MAX = 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef struct {
		logic [PIX_W-1:0] average;
		logic [SUM_W-1:0] block_sum;
		logic [CNT_W-1:0] pixel_count;
		logic [IDX_OUT_W-1:0] block_row;
		logic [IDX_OUT_W-1:0] block_col;
		logic image_done;
	} block_result_t;

	// Tracks the raster position and the band sums, and holds the block results still owed.
	class block_scoreboard;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		logic [SUM_W-1:0] band_sum [BAND_DEPTH];
		int unsigned col, row, row_in_band, col_in_block, blk_col, blk_row;
		block_result_t owed_q[$];
		int faults;

		function new();
			width_reg = DIM_W'(DIM_RESET);
			height_reg = DIM_W'(DIM_RESET);
			foreach (band_sum[i]) band_sum[i] = '0;
			faults = 0;
			restart();
		endfunction

		function void restart();
			col = 0;
			row = 0;
			row_in_band = 0;
			col_in_block = 0;
			blk_col = 0;
			blk_row = 0;
		endfunction

		function int unsigned clamp_dim(input logic [DIM_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_WIDTH) return MAX_WIDTH;
			return v;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = val;
					restart();
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = val;
					restart();
				end
				default: ;
			endcase
		endfunction

		function void note_pixel(input logic [PIX_W-1:0] p);
			int unsigned w, h, bc, sum, cnt;
			bit last_col, last_row, right, bottom;
			block_result_t res;
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			bc = (blk_col >= BAND_DEPTH) ? BAND_DEPTH - 1 : blk_col;
			last_col = col + 1 >= w;
			last_row = row + 1 >= h;
			right = (col_in_block + 1 >= BLOCK_SIZE) || last_col;
			bottom = (row_in_band + 1 >= BLOCK_SIZE) || last_row;
			// The first pixel of a block starts its sum, so stale entries never leak in.
			if (row_in_band == 0 && col_in_block == 0)
				sum = p;
			else
				sum = band_sum[bc] + p;
			sum &= 12'hFFF;
			band_sum[bc] = SUM_W'(sum);
			if (right && bottom) begin
				cnt = (col_in_block + 1) * (row_in_band + 1);
				res.average = PIX_W'((2 * sum + cnt) / (2 * cnt));
				res.block_sum = SUM_W'(sum);
				res.pixel_count = CNT_W'(cnt);
				res.block_row = IDX_OUT_W'(blk_row);
				res.block_col = IDX_OUT_W'(blk_col);
				res.image_done = last_col && last_row;
				owed_q.push_back(res);
			end
			if (last_col) begin
				col = 0;
				col_in_block = 0;
				blk_col = 0;
				if (last_row) begin
					restart();
				end else begin
					row++;
					row_in_band++;
					if (row_in_band >= BLOCK_SIZE) begin
						row_in_band = 0;
						blk_row++;
					end
				end
			end else begin
				col++;
				col_in_block++;
				if (col_in_block >= BLOCK_SIZE) begin
					col_in_block = 0;
					blk_col++;
				end
			end
		endfunction

		function void report(input string msg);
			if (faults < MAX_REPORTS) $display("MISMATCH: %s", msg);
			faults++;
		endfunction

		function void check_result(input logic [TDATA_OUT_W-1:0] data, input logic last);
			block_result_t exp_r;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected result tdata=%h tlast=%b", data, last));
				return;
			end
			exp_r = owed_q.pop_front();
			if (data[7:0] !== exp_r.average)
				report($sformatf("average exp %0d got %0d", exp_r.average, data[7:0]));
			if (data[19:8] !== exp_r.block_sum)
				report($sformatf("block_sum exp %0d got %0d", exp_r.block_sum, data[19:8]));
			if (data[23:20] !== exp_r.pixel_count)
				report($sformatf("pixel_count exp %0d got %0d", exp_r.pixel_count, data[23:20]));
			if (data[32:24] !== exp_r.block_row)
				report($sformatf("block_row exp %0d got %0d", exp_r.block_row, data[32:24]));
			if (data[41:33] !== exp_r.block_col)
				report($sformatf("block_col exp %0d got %0d", exp_r.block_col, data[41:33]));
			if (data[47:42] !== '0)
				report($sformatf("pad bits exp 0 got %h", data[47:42]));
			if (last !== exp_r.image_done)
				report($sformatf("image_done exp %b got %b", exp_r.image_done, last));
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [PIX_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;

	block_scoreboard score = new();
	int src_idle_pct = IDLE_PCT;
	int snk_idle_pct = IDLE_PCT;
	bit hold_req = 1'b0;
	int stuck_cycles = 0;
	int cur_w = DIM_RESET;
	int cur_h = DIM_RESET;

	block_average_3x3 #(.MAX_WIDTH(MAX_WIDTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Handshakes are sampled mid-cycle, where every signal has settled.
	always @(negedge clk) begin
		if (m_tvalid && m_tready) score.check_result(m_tdata, m_tlast);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT) @(negedge clk);
		$display("Verification failed");
		$finish;
	end

	// Result receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
		int r;
		if (mode == FILL_MAX) return 8'hFF;
		r = $urandom_range(7);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return PIX_W'($urandom_range(255));
	endfunction

	function automatic int eff_dim(input int v);
		if (v == 0) return 1;
		return (v > MAX_WIDTH) ? MAX_WIDTH : v;
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] p);
		bit ok;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		score.note_pixel(p);
	endtask

	task automatic send_pixels(input int n, input int mode);
		for (int i = 0; i < n; i++) send_pixel(pick_pixel(mode));
		s_tvalid <= 1'b0;
	endtask

	// Wait for every owed result, then for pixels that cause none to drain.
	task automatic settle();
		while (score.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		score.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_dims(input int w, input int h);
		settle();
		write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
		write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
		cur_w = w;
		cur_h = h;
	endtask

	initial begin
		int random_sent, w, h, area, npix, k, split;
		bit write_w, write_h;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions are 1024 x 1024, so a few pixels produce nothing yet.
		send_pixels(3, FILL_MIXED);

		// Full 3x3 block of the largest value gives the largest sum.
		set_dims(3, 3);
		send_pixels(9, FILL_MAX);

		// A sum of 1 over 2 pixels checks the half-up rounding.
		set_dims(2, 1);
		send_pixel(8'h00);
		send_pixel(8'h01);
		s_tvalid <= 1'b0;

		// Width zero is taken as one: every pixel is a whole image.
		set_dims(0, 1);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		s_tvalid <= 1'b0;

		// Writes to indexes past the register list must not restart the image.
		set_dims(4, 2);
		send_pixels(4, FILL_MIXED);
		settle();
		write_reg(REG_UNUSED_2, 11'h7FF);
		write_reg(REG_UNUSED_3, 11'h000);
		send_pixels(4, FILL_MIXED);

		// An oversized width saturates: one row of the widest image.
		set_dims(2047, 1);
		send_pixels(MAX_WIDTH, FILL_MIXED);

		// Long receiver hold-off while pixels keep coming, so the input stalls.
		set_dims(3, 3);
		hold_req = 1'b1;
		send_pixels(90, FILL_MIXED);

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= 150 && random_sent < 400) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else begin
				src_idle_pct = IDLE_PCT;
				snk_idle_pct = IDLE_PCT;
			end
			k = $urandom_range(99);
			if (k < 4) begin
				w = $urandom_range(600, 2047);
				h = 1;
			end else if (k < 20) begin
				w = $urandom_range(13, 64);
				h = $urandom_range(1, 6);
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 10);
			end
			if ($urandom_range(19) == 0) w = 0;
			if ($urandom_range(19) == 0) h = 0;
			// Usually both registers are written; sometimes only one of them.
			k = $urandom_range(9);
			write_w = (k != 0);
			write_h = (k != 1);
			settle();
			if (write_w) begin
				write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
				cur_w = w;
			end
			if (write_h) begin
				write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
				cur_h = h;
			end
			area = eff_dim(cur_w) * eff_dim(cur_h);
			if (area > 1500) area = eff_dim(cur_w);
			k = $urandom_range(9);
			if (k < 6)
				npix = area * ((area <= 60) ? $urandom_range(1, 3) : 1);
			else if (k < 9)
				npix = $urandom_range(1, area);
			else
				npix = area + $urandom_range(0, area - 1);
			if (npix > RANDOM_ITEMS - random_sent) npix = RANDOM_ITEMS - random_sent;
			k = ($urandom_range(9) == 0) ? FILL_MAX : FILL_MIXED;
			if (npix > 1 && $urandom_range(9) == 0) begin
				split = $urandom_range(1, npix - 1);
				send_pixels(split, k);
				settle();
				write_reg(($urandom_range(1) != 0) ? REG_UNUSED_2 : REG_UNUSED_3,
					DIM_W'($urandom_range(2047)));
				send_pixels(npix - split, k);
			end else begin
				send_pixels(npix, k);
			end
			random_sent += npix;
		end

		settle();
		if (score.pending() != 0) score.faults++;
		if (score.faults == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
